/* hw/rtl/rtn_pkg.sv */
`timescale 1ns / 1ps
package rtn_pkg;

    localparam int COORD_BITS   = 32;
    localparam int ID_BITS      = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int STEP_BITS    = 5;
    localparam int ACC_BITS     = 50;
    localparam int NRM_BITS     = 49;
    localparam int DIV_NUM_BITS = 66;
    localparam int DIV_DEN_BITS = 50;
    localparam int DIV_CNT_BITS = 7;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_EPSILON  = 3'd6;

    localparam logic [STEP_BITS-1:0] STEP_DET_END = 5'd8;
    localparam logic [STEP_BITS-1:0] STEP_TN_END  = 5'd23;
    localparam logic [STEP_BITS-1:0] STEP_NORMAL  = 5'd24;
    localparam logic [STEP_BITS-1:0] STEP_END     = 5'd29;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [31:0] t_q16;
    typedef logic [2:0][31:0] t_vec3;

    typedef struct packed {
        t_coord vertex_a_x;
        t_coord vertex_a_y;
        t_coord vertex_a_z;
        t_coord vertex_b_x;
        t_coord vertex_b_y;
        t_coord vertex_b_z;
        t_coord vertex_c_x;
        t_coord vertex_c_y;
        t_coord vertex_c_z;
        logic [ID_BITS-1:0] triangle_id;
        logic last_triangle;
    } t_tri;

    typedef struct packed {
        logic hit;
        t_q16 distance;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [ID_BITS-1:0] hit_triangle;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] index;
        logic [COORD_BITS-1:0] data;
    } t_cfg;

    typedef enum logic [2:0] {
        OPV_E1, OPV_E2, OPV_S, OPV_D, OPV_P, OPV_Q
    } t_opv;

    typedef enum logic [2:0] {
        DST_P, DST_Q, DST_DET, DST_U, DST_V, DST_TN, DST_N
    } t_dst;

    typedef struct packed {
        t_opv a_vec;
        logic [1:0] a_cmp;
        t_opv b_vec;
        logic [1:0] b_cmp;
        logic sub;
        logic first;
        logic wr;
        t_dst dst;
        logic [1:0] d_cmp;
    } t_step;

    function automatic t_q16 coord_sat(t_coord v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > 64'(Q_MAX)) return Q_MAX;
        if (w < 64'(Q_MIN)) return Q_MIN;
        return w[31:0];
    endfunction

    function automatic t_q16 sat33(logic signed [32:0] v);
        if (v > 33'(Q_MAX)) return Q_MAX;
        if (v < 33'(Q_MIN)) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic t_q16 sat_acc(logic signed [ACC_BITS-1:0] v);
        if (v > ACC_BITS'(Q_MAX)) return Q_MAX;
        if (v < ACC_BITS'(Q_MIN)) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic t_step mk(t_opv av, logic [1:0] ac, t_opv bv, logic [1:0] bc,
                                 logic sub, logic first, logic wr, t_dst dst,
                                 logic [1:0] dc);
        t_step s;
        s.a_vec = av;
        s.a_cmp = ac;
        s.b_vec = bv;
        s.b_cmp = bc;
        s.sub   = sub;
        s.first = first;
        s.wr    = wr;
        s.dst   = dst;
        s.d_cmp = dc;
        return s;
    endfunction

    function automatic t_step step_of(logic [STEP_BITS-1:0] idx);
        case (idx)
            5'd0:  return mk(OPV_D,  2'd1, OPV_E2, 2'd2, 1'b0, 1'b1, 1'b0, DST_P, 2'd0);
            5'd1:  return mk(OPV_D,  2'd2, OPV_E2, 2'd1, 1'b1, 1'b0, 1'b1, DST_P, 2'd0);
            5'd2:  return mk(OPV_D,  2'd2, OPV_E2, 2'd0, 1'b0, 1'b1, 1'b0, DST_P, 2'd1);
            5'd3:  return mk(OPV_D,  2'd0, OPV_E2, 2'd2, 1'b1, 1'b0, 1'b1, DST_P, 2'd1);
            5'd4:  return mk(OPV_D,  2'd0, OPV_E2, 2'd1, 1'b0, 1'b1, 1'b0, DST_P, 2'd2);
            5'd5:  return mk(OPV_D,  2'd1, OPV_E2, 2'd0, 1'b1, 1'b0, 1'b1, DST_P, 2'd2);
            5'd6:  return mk(OPV_E1, 2'd0, OPV_P,  2'd0, 1'b0, 1'b1, 1'b0, DST_DET, 2'd0);
            5'd7:  return mk(OPV_E1, 2'd1, OPV_P,  2'd1, 1'b0, 1'b0, 1'b0, DST_DET, 2'd0);
            5'd8:  return mk(OPV_E1, 2'd2, OPV_P,  2'd2, 1'b0, 1'b0, 1'b1, DST_DET, 2'd0);
            5'd9:  return mk(OPV_S,  2'd1, OPV_E1, 2'd2, 1'b0, 1'b1, 1'b0, DST_Q, 2'd0);
            5'd10: return mk(OPV_S,  2'd2, OPV_E1, 2'd1, 1'b1, 1'b0, 1'b1, DST_Q, 2'd0);
            5'd11: return mk(OPV_S,  2'd2, OPV_E1, 2'd0, 1'b0, 1'b1, 1'b0, DST_Q, 2'd1);
            5'd12: return mk(OPV_S,  2'd0, OPV_E1, 2'd2, 1'b1, 1'b0, 1'b1, DST_Q, 2'd1);
            5'd13: return mk(OPV_S,  2'd0, OPV_E1, 2'd1, 1'b0, 1'b1, 1'b0, DST_Q, 2'd2);
            5'd14: return mk(OPV_S,  2'd1, OPV_E1, 2'd0, 1'b1, 1'b0, 1'b1, DST_Q, 2'd2);
            5'd15: return mk(OPV_S,  2'd0, OPV_P,  2'd0, 1'b0, 1'b1, 1'b0, DST_U, 2'd0);
            5'd16: return mk(OPV_S,  2'd1, OPV_P,  2'd1, 1'b0, 1'b0, 1'b0, DST_U, 2'd0);
            5'd17: return mk(OPV_S,  2'd2, OPV_P,  2'd2, 1'b0, 1'b0, 1'b1, DST_U, 2'd0);
            5'd18: return mk(OPV_D,  2'd0, OPV_Q,  2'd0, 1'b0, 1'b1, 1'b0, DST_V, 2'd0);
            5'd19: return mk(OPV_D,  2'd1, OPV_Q,  2'd1, 1'b0, 1'b0, 1'b0, DST_V, 2'd0);
            5'd20: return mk(OPV_D,  2'd2, OPV_Q,  2'd2, 1'b0, 1'b0, 1'b1, DST_V, 2'd0);
            5'd21: return mk(OPV_E2, 2'd0, OPV_Q,  2'd0, 1'b0, 1'b1, 1'b0, DST_TN, 2'd0);
            5'd22: return mk(OPV_E2, 2'd1, OPV_Q,  2'd1, 1'b0, 1'b0, 1'b0, DST_TN, 2'd0);
            5'd23: return mk(OPV_E2, 2'd2, OPV_Q,  2'd2, 1'b0, 1'b0, 1'b1, DST_TN, 2'd0);
            5'd24: return mk(OPV_E1, 2'd1, OPV_E2, 2'd2, 1'b0, 1'b1, 1'b0, DST_N, 2'd0);
            5'd25: return mk(OPV_E1, 2'd2, OPV_E2, 2'd1, 1'b1, 1'b0, 1'b1, DST_N, 2'd0);
            5'd26: return mk(OPV_E1, 2'd2, OPV_E2, 2'd0, 1'b0, 1'b1, 1'b0, DST_N, 2'd1);
            5'd27: return mk(OPV_E1, 2'd0, OPV_E2, 2'd2, 1'b1, 1'b0, 1'b1, DST_N, 2'd1);
            5'd28: return mk(OPV_E1, 2'd0, OPV_E2, 2'd1, 1'b0, 1'b1, 1'b0, DST_N, 2'd2);
            5'd29: return mk(OPV_E1, 2'd1, OPV_E2, 2'd0, 1'b1, 1'b0, 1'b1, DST_N, 2'd2);
            default: return mk(OPV_E1, 2'd0, OPV_E2, 2'd0, 1'b0, 1'b1, 1'b0, DST_N, 2'd0);
        endcase
    endfunction

    function automatic t_q16 comp_of(t_vec3 v, logic [1:0] c);
        case (c)
            2'd0:    return $signed(v[0]);
            2'd1:    return $signed(v[1]);
            default: return $signed(v[2]);
        endcase
    endfunction

endpackage

/* hw/rtl/rtn_tri_if.sv */
`timescale 1ns / 1ps
interface rtn_tri_if;
    logic valid;
    logic ready;
    rtn_pkg::t_tri payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/rtn_res_if.sv */
`timescale 1ns / 1ps
interface rtn_res_if;
    logic valid;
    logic ready;
    rtn_pkg::t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/rtn_cfg_if.sv */
`timescale 1ns / 1ps
interface rtn_cfg_if;
    logic valid;
    logic ready;
    rtn_pkg::t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/rtn_mul.sv */
`timescale 1ns / 1ps
module rtn_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);
    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule

/* hw/rtl/rtn_div.sv */
`timescale 1ns / 1ps
module rtn_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [rtn_pkg::DIV_NUM_BITS-1:0]    i_num,
    input  logic [rtn_pkg::DIV_DEN_BITS-1:0]    i_den,
    input  logic [rtn_pkg::DIV_CNT_BITS-1:0]    i_count,
    output logic                                o_done,
    output logic [rtn_pkg::DIV_NUM_BITS-1:0]    o_quo
);
    logic                                r_busy;
    logic                                r_done;
    logic [rtn_pkg::DIV_CNT_BITS-1:0]    r_cnt;
    logic [rtn_pkg::DIV_NUM_BITS-1:0]    r_num;
    logic [rtn_pkg::DIV_NUM_BITS-1:0]    r_quo;
    logic [rtn_pkg::DIV_DEN_BITS-1:0]    r_den;
    logic [rtn_pkg::DIV_DEN_BITS-1:0]    r_rem;
    logic [rtn_pkg::DIV_DEN_BITS:0]      trial;
    logic [rtn_pkg::DIV_DEN_BITS+1:0]    diff;
    logic                                ge;

    assign trial = {r_rem, r_num[rtn_pkg::DIV_NUM_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_den};
    assign ge    = !diff[rtn_pkg::DIV_DEN_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == rtn_pkg::DIV_CNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_cnt <= i_count;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[rtn_pkg::DIV_NUM_BITS-2:0], 1'b0};
            r_rem <= ge ? diff[rtn_pkg::DIV_DEN_BITS-1:0] : trial[rtn_pkg::DIV_DEN_BITS-1:0];
            r_quo <= {r_quo[rtn_pkg::DIV_NUM_BITS-2:0], ge};
            r_cnt <= r_cnt - rtn_pkg::DIV_CNT_BITS'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* hw/rtl/rtn_sqrt.sv */
`timescale 1ns / 1ps
module rtn_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] sum;

    assign sum = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_x >= sum) begin
                r_x <= r_x - sum;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];
endmodule

/* hw/rtl/ray_triangle_nearest_hit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                                    Transaction
// i_cfg     in   index, data (ray origin/dir, epsilon)     valid & ready, always ready
// i_tri     in   vertices a/b/c, triangle_id, last         valid & ready, ready when idle
// o_res     out  hit, distance, normal_x/y/z, hit_triangle valid & ready, one per last
//
// A triangle runs up to 24 products of the hit test on the shared multiplier, with the
// parallel check, the bounds check and the finish; a triangle that passes adds the serial t
// division and the compare; a kept hit adds the normal products, the normalizing shifts,
// the squares, the root and the three normal divisions.
// Reset is synchronous, active low. A result waits in the output register while the next
// triangle is accepted; the block stalls only when a second result finds it still full.
module ray_triangle_nearest_hit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtn_cfg_if.sink       i_cfg,
    rtn_tri_if.sink       i_tri,
    rtn_res_if.source     o_res
);
    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_MUL    = 17'h00002,
        S_ACC    = 17'h00004,
        S_PAR    = 17'h00008,
        S_CHECK  = 17'h00010,
        S_DIVT   = 17'h00020,
        S_KEEP   = 17'h00040,
        S_NPREP  = 17'h00080,
        S_NSHIFT = 17'h00100,
        S_SQMUL  = 17'h00200,
        S_SQACC  = 17'h00400,
        S_SQST   = 17'h00800,
        S_SQRT   = 17'h01000,
        S_NDST   = 17'h02000,
        S_NDIV   = 17'h04000,
        S_COMMIT = 17'h08000,
        S_FINISH = 17'h10000
    } t_state;

    t_state r_state;
    logic [rtn_pkg::STEP_BITS-1:0] r_step;
    rtn_pkg::t_q16 r_org [3];
    rtn_pkg::t_q16 r_dir [3];
    logic [15:0] r_eps;
    rtn_pkg::t_vec3 r_e1, r_e2, r_s, r_p, r_q, vd;
    logic signed [rtn_pkg::ACC_BITS-1:0] r_acc, r_det, r_u, r_v, r_tn;
    logic signed [rtn_pkg::NRM_BITS-1:0] r_n [3];
    logic [rtn_pkg::ID_BITS-1:0] r_id;
    logic r_last, r_inv, r_tneg;
    rtn_pkg::t_q16 r_t;
    logic [49:0] r_m [3];
    logic [2:0] r_neg;
    logic [1:0] r_k;
    logic [63:0] r_sq;
    logic [31:0] r_len;
    logic signed [15:0] r_nq [3];
    rtn_pkg::t_q16 r_best_dist;
    logic signed [15:0] r_best_n [3];
    logic [rtn_pkg::ID_BITS-1:0] r_best_id;
    logic r_any;
    logic r_out_valid;
    rtn_pkg::t_res r_out;

    rtn_pkg::t_step st;
    rtn_pkg::t_q16 op_a, op_b, mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [47:0] pm;
    logic signed [rtn_pkg::ACC_BITS-1:0] n_acc;
    logic signed [rtn_pkg::ACC_BITS:0] adet, uu, vv;
    logic signed [rtn_pkg::ACC_BITS+1:0] uv;
    logic chk_fail, par_skip;
    logic [49:0] tn_mag, big, m_sel;
    logic [49:0] nc_mag [3];
    logic signed [rtn_pkg::ACC_BITS-1:0] nc [3];
    logic div_start, div_done, sqrt_start, sqrt_done;
    logic [rtn_pkg::DIV_NUM_BITS-1:0] div_num, div_quo;
    logic [rtn_pkg::DIV_DEN_BITS-1:0] div_den;
    logic [rtn_pkg::DIV_CNT_BITS-1:0] div_cnt;
    logic [31:0] root;
    rtn_pkg::t_q16 t_sat;
    logic signed [15:0] nq_val;
    logic out_load, in_acc;
    rtn_pkg::t_q16 va [3], vb [3], vc [3];

    function automatic rtn_pkg::t_vec3 pick(rtn_pkg::t_opv v, rtn_pkg::t_vec3 e1,
                                            rtn_pkg::t_vec3 e2, rtn_pkg::t_vec3 s,
                                            rtn_pkg::t_vec3 d, rtn_pkg::t_vec3 p,
                                            rtn_pkg::t_vec3 q);
        case (v)
            rtn_pkg::OPV_E1: return e1;
            rtn_pkg::OPV_E2: return e2;
            rtn_pkg::OPV_S:  return s;
            rtn_pkg::OPV_D:  return d;
            rtn_pkg::OPV_P:  return p;
            default:         return q;
        endcase
    endfunction

    assign st = rtn_pkg::step_of(r_step);
    assign vd = {r_dir[2], r_dir[1], r_dir[0]};
    assign op_a = rtn_pkg::comp_of(pick(st.a_vec, r_e1, r_e2, r_s, vd, r_p, r_q), st.a_cmp);
    assign op_b = rtn_pkg::comp_of(pick(st.b_vec, r_e1, r_e2, r_s, vd, r_p, r_q), st.b_cmp);

    always_comb begin
        case (r_k)
            2'd0:    m_sel = r_m[0];
            2'd1:    m_sel = r_m[1];
            default: m_sel = r_m[2];
        endcase
    end

    assign mul_a = (r_state == S_SQMUL) ? $signed({2'b00, m_sel[29:0]}) : op_a;
    assign mul_b = mul_a == op_a && r_state != S_SQMUL ? op_b : mul_a;

    rtn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign pm = prod[63:16];
    assign n_acc = st.first ? rtn_pkg::ACC_BITS'(pm)
                 : (st.sub ? r_acc - rtn_pkg::ACC_BITS'(pm) : r_acc + rtn_pkg::ACC_BITS'(pm));

    assign adet = r_det[rtn_pkg::ACC_BITS-1] ? -(rtn_pkg::ACC_BITS+1)'(r_det)
                                              : (rtn_pkg::ACC_BITS+1)'(r_det);
    assign uu = r_det[rtn_pkg::ACC_BITS-1] ? -(rtn_pkg::ACC_BITS+1)'(r_u)
                                            : (rtn_pkg::ACC_BITS+1)'(r_u);
    assign vv = r_det[rtn_pkg::ACC_BITS-1] ? -(rtn_pkg::ACC_BITS+1)'(r_v)
                                            : (rtn_pkg::ACC_BITS+1)'(r_v);
    assign uv = (rtn_pkg::ACC_BITS+2)'(uu) + (rtn_pkg::ACC_BITS+2)'(vv);
    assign chk_fail = uu < 0 || uu > adet || vv < 0 || uv > (rtn_pkg::ACC_BITS+2)'(adet);
    assign par_skip = r_det == '0 || adet < $signed({35'd0, r_eps});
    assign tn_mag = r_tn[rtn_pkg::ACC_BITS-1] ? 50'(-r_tn) : 50'(r_tn);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nc[i] = r_inv ? -rtn_pkg::ACC_BITS'(r_n[i]) : rtn_pkg::ACC_BITS'(r_n[i]);
            nc_mag[i] = nc[i][rtn_pkg::ACC_BITS-1] ? 50'(-nc[i]) : 50'(nc[i]);
        end
        big = r_m[0];
        if (r_m[1] > big) big = r_m[1];
        if (r_m[2] > big) big = r_m[2];
    end

    assign div_start = (r_state == S_CHECK && !chk_fail) || r_state == S_NDST;
    assign div_num = (r_state == S_CHECK) ? {tn_mag, 16'd0} : {m_sel[29:0], 36'd0};
    assign div_den = (r_state == S_CHECK) ? adet[rtn_pkg::DIV_DEN_BITS-1:0] : {18'd0, r_len};
    assign div_cnt = (r_state == S_CHECK) ? rtn_pkg::DIV_CNT_BITS'(66)
                                           : rtn_pkg::DIV_CNT_BITS'(44);

    rtn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_count (div_cnt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign sqrt_start = r_state == S_SQST;

    rtn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     (r_sq),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    always_comb begin
        if (r_tneg) begin
            t_sat = (div_quo > 66'h8000_0000) ? rtn_pkg::Q_MIN : -$signed(div_quo[31:0]);
        end else begin
            t_sat = (div_quo > 66'h7FFF_FFFF) ? rtn_pkg::Q_MAX : $signed(div_quo[31:0]);
        end
        nq_val = r_neg[r_k] ? -$signed(div_quo[15:0]) : $signed(div_quo[15:0]);
    end

    assign in_acc   = i_tri.valid && i_tri.ready;
    assign out_load = r_state == S_FINISH && r_last && (!r_out_valid || o_res.ready);
    assign i_tri.ready = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_out;

    assign va[0] = rtn_pkg::coord_sat(i_tri.payload.vertex_a_x);
    assign va[1] = rtn_pkg::coord_sat(i_tri.payload.vertex_a_y);
    assign va[2] = rtn_pkg::coord_sat(i_tri.payload.vertex_a_z);
    assign vb[0] = rtn_pkg::coord_sat(i_tri.payload.vertex_b_x);
    assign vb[1] = rtn_pkg::coord_sat(i_tri.payload.vertex_b_y);
    assign vb[2] = rtn_pkg::coord_sat(i_tri.payload.vertex_b_z);
    assign vc[0] = rtn_pkg::coord_sat(i_tri.payload.vertex_c_x);
    assign vc[1] = rtn_pkg::coord_sat(i_tri.payload.vertex_c_y);
    assign vc[2] = rtn_pkg::coord_sat(i_tri.payload.vertex_c_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= 32'sd65536;
            r_eps    <= 16'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                rtn_pkg::REG_ORIGIN_X: r_org[0] <= rtn_pkg::coord_sat(i_cfg.payload.data);
                rtn_pkg::REG_ORIGIN_Y: r_org[1] <= rtn_pkg::coord_sat(i_cfg.payload.data);
                rtn_pkg::REG_ORIGIN_Z: r_org[2] <= rtn_pkg::coord_sat(i_cfg.payload.data);
                rtn_pkg::REG_DIR_X:    r_dir[0] <= rtn_pkg::coord_sat(i_cfg.payload.data);
                rtn_pkg::REG_DIR_Y:    r_dir[1] <= rtn_pkg::coord_sat(i_cfg.payload.data);
                rtn_pkg::REG_DIR_Z:    r_dir[2] <= rtn_pkg::coord_sat(i_cfg.payload.data);
                rtn_pkg::REG_EPSILON:  r_eps    <= i_cfg.payload.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_best_dist <= rtn_pkg::Q_MAX;
            r_best_n[0] <= '0;
            r_best_n[1] <= '0;
            r_best_n[2] <= '0;
            r_best_id   <= '0;
            r_any       <= 1'b0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_step <= r_step + rtn_pkg::STEP_BITS'(1);
                    if (r_step == rtn_pkg::STEP_DET_END) r_state <= S_PAR;
                    else if (r_step == rtn_pkg::STEP_TN_END) r_state <= S_CHECK;
                    else if (r_step == rtn_pkg::STEP_END) r_state <= S_NPREP;
                    else r_state <= S_MUL;
                end
                S_PAR: r_state <= par_skip ? S_FINISH : S_MUL;
                S_CHECK: r_state <= chk_fail ? S_FINISH : S_DIVT;
                S_DIVT: if (div_done) r_state <= S_KEEP;
                S_KEEP: r_state <= (r_t < r_best_dist) ? S_MUL : S_FINISH;
                S_NPREP: begin
                    if (nc_mag[0] == '0 && nc_mag[1] == '0 && nc_mag[2] == '0) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_state <= S_NSHIFT;
                    end
                end
                S_NSHIFT: if (big[49:30] == '0 && big[29]) r_state <= S_SQMUL;
                S_SQMUL: r_state <= S_SQACC;
                S_SQACC: r_state <= (r_k == 2'd2) ? S_SQST : S_SQMUL;
                S_SQST: r_state <= S_SQRT;
                S_SQRT: if (sqrt_done) r_state <= S_NDST;
                S_NDST: r_state <= S_NDIV;
                S_NDIV: if (div_done) r_state <= (r_k == 2'd2) ? S_COMMIT : S_NDST;
                S_COMMIT: begin
                    r_best_dist <= r_t;
                    r_best_n[0] <= r_nq[0];
                    r_best_n[1] <= r_nq[1];
                    r_best_n[2] <= r_nq[2];
                    r_best_id   <= r_id;
                    r_any       <= 1'b1;
                    r_state     <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (out_load) begin
                        r_best_dist <= rtn_pkg::Q_MAX;
                        r_best_n[0] <= '0;
                        r_best_n[1] <= '0;
                        r_best_n[2] <= '0;
                        r_best_id   <= '0;
                        r_any       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= rtn_pkg::sat33(33'(vb[i]) - 33'(va[i]));
                        r_e2[i] <= rtn_pkg::sat33(33'(vc[i]) - 33'(va[i]));
                        r_s[i]  <= rtn_pkg::sat33(33'(r_org[i]) - 33'(va[i]));
                    end
                    r_id   <= i_tri.payload.triangle_id;
                    r_last <= i_tri.payload.last_triangle;
                end
            end
            S_ACC: begin
                r_acc <= n_acc;
                if (st.wr) begin
                    case (st.dst)
                        rtn_pkg::DST_P:   r_p[st.d_cmp] <= rtn_pkg::sat_acc(n_acc);
                        rtn_pkg::DST_Q:   r_q[st.d_cmp] <= rtn_pkg::sat_acc(n_acc);
                        rtn_pkg::DST_DET: r_det <= n_acc;
                        rtn_pkg::DST_U:   r_u <= n_acc;
                        rtn_pkg::DST_V:   r_v <= n_acc;
                        rtn_pkg::DST_TN:  r_tn <= n_acc;
                        default:          r_n[st.d_cmp] <= n_acc[rtn_pkg::NRM_BITS-1:0];
                    endcase
                end
            end
            S_CHECK: begin
                r_inv  <= r_det[rtn_pkg::ACC_BITS-1];
                r_tneg <= r_tn[rtn_pkg::ACC_BITS-1] ^ r_det[rtn_pkg::ACC_BITS-1];
            end
            S_DIVT: if (div_done) r_t <= t_sat;
            S_NPREP: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= nc_mag[i];
                    r_neg[i] <= nc[i][rtn_pkg::ACC_BITS-1];
                    r_nq[i]  <= '0;
                end
            end
            S_NSHIFT: begin
                r_k  <= '0;
                r_sq <= '0;
                for (int i = 0; i < 3; i++) begin
                    if (big[49:30] != '0) r_m[i] <= r_m[i] >> 1;
                    else if (!big[29]) r_m[i] <= r_m[i] << 1;
                end
            end
            S_SQACC: begin
                r_sq <= r_sq + 64'(prod);
                r_k  <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            S_SQRT: if (sqrt_done) r_len <= root;
            S_NDIV: begin
                if (div_done) begin
                    r_nq[r_k] <= nq_val;
                    r_k <= r_k + 2'd1;
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    r_out.hit          <= r_any && r_best_dist >= 0;
                    r_out.distance     <= (r_any && r_best_dist >= 0) ? r_best_dist : '0;
                    r_out.normal_x     <= (r_any && r_best_dist >= 0) ? r_best_n[0] : '0;
                    r_out.normal_y     <= (r_any && r_best_dist >= 0) ? r_best_n[1] : '0;
                    r_out.normal_z     <= (r_any && r_best_dist >= 0) ? r_best_n[2] : '0;
                    r_out.hit_triangle <= (r_any && r_best_dist >= 0) ? r_best_id : '0;
                end
            end
            default: ;
        endcase
    end
endmodule
